// ===== src/float_to_int_saturating_truncate_defines.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef FLOAT_TO_INT_SATURATING_TRUNCATE_DEFINES_SVH
`define FLOAT_TO_INT_SATURATING_TRUNCATE_DEFINES_SVH

// Check that a property holds on every clock while out of reset.
`define F2I_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("f2i check failed");

// Check that a condition implies another in the next cycle.
`define F2I_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("f2i check failed");

`endif

// ===== src/f2i_pkg.sv =====
`default_nettype none
package f2i_pkg;

  typedef enum logic [1:0] {
    SIZE_8  = 2'd0,
    SIZE_16 = 2'd1,
    SIZE_32 = 2'd2,
    SIZE_64 = 2'd3
  } size_e;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_SAT  = 2'd1,
    CLS_NUM  = 2'd2
  } cls_e;

  // unpacked operand after stage one
  typedef struct packed {
    logic        neg;
    cls_e        cls;
    logic [52:0] mant;
    logic [5:0]  sh_left;
    logic [5:0]  sh_right;
    logic        left;
    size_e       size;
  } unp_t;

  function automatic logic [63:0] sat_val(input size_e sz, input logic neg);
    logic [63:0] r;
    begin
      case (sz)
        SIZE_8:  r = neg ? {{57{1'b1}}, 7'd0}  : {57'd0, {7{1'b1}}};
        SIZE_16: r = neg ? {{49{1'b1}}, 15'd0} : {49'd0, {15{1'b1}}};
        SIZE_32: r = neg ? {{33{1'b1}}, 31'd0} : {33'd0, {31{1'b1}}};
        default: r = neg ? {1'b1, 63'd0}       : {1'b0, {63{1'b1}}};
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// ===== src/f2i_unpack.sv =====
`default_nettype none
module f2i_unpack (
  input  wire logic [63:0]  bits_i,
  input  wire logic         single_i,
  input  wire logic [1:0]   size_i,
  output f2i_pkg::unp_t     unp_o
);
  logic [10:0] expo;
  logic [51:0] frac;
  logic        all_ones;
  logic [11:0] e;
  logic [6:0]  nm1;
  logic [5:0]  fb;

  always_comb begin
    unp_o = '0;
    unp_o.size = f2i_pkg::size_e'(size_i);
    if (single_i) begin
      unp_o.neg = bits_i[31];
      expo      = {3'd0, bits_i[30:23]};
      frac      = {29'd0, bits_i[22:0]};
      all_ones  = &bits_i[30:23];
      e         = {4'd0, bits_i[30:23]} - 12'd127;
      fb        = 6'd23;
    end else begin
      unp_o.neg = bits_i[63];
      expo      = bits_i[62:52];
      frac      = bits_i[51:0];
      all_ones  = &bits_i[62:52];
      e         = {1'b0, bits_i[62:52]} - 12'd1023;
      fb        = 6'd52;
    end
    nm1 = 7'((8 << size_i) - 1);
    unp_o.mant = single_i ? {29'd0, 1'b1, bits_i[22:0]} : {1'b1, frac};
    if (all_ones) begin
      unp_o.cls = (frac != '0) ? f2i_pkg::CLS_ZERO : f2i_pkg::CLS_SAT;
    end else if (expo == '0 || e[11]) begin
      unp_o.cls = f2i_pkg::CLS_ZERO;
    end else if (e >= {5'd0, nm1}) begin
      unp_o.cls = f2i_pkg::CLS_SAT;
    end else begin
      unp_o.cls = f2i_pkg::CLS_NUM;
    end
    unp_o.left     = e[5:0] >= fb;
    unp_o.sh_left  = e[5:0] - fb;
    unp_o.sh_right = fb - e[5:0];
  end
endmodule
`default_nettype wire

// ===== src/f2i_shift.sv =====
`default_nettype none
module f2i_shift (
  input  wire f2i_pkg::unp_t  unp_i,
  output logic [63:0]         mag_o
);
  logic [63:0] m;
  always_comb begin
    m = {11'd0, unp_i.mant};
    mag_o = unp_i.left ? (m << unp_i.sh_left) : (m >> unp_i.sh_right);
  end
endmodule
`default_nettype wire

// ===== src/float_to_int_saturating_truncate.sv =====
// Float to signed integer converter, truncating toward zero with saturation.
// Input beat: s_axis_tdata carries float_bits (binary32 in the low 32 bits),
// s_axis_tuser carries source_single and dest_size. Output beat:
// m_axis_tdata carries the result sign-extended to 64 bits.
// NaN gives zero; overflow and infinities clamp to the destination limits.
// Throughput: one beat per cycle unless the receiver stalls, set by the
// three-stage pipe (unpack, shift, negate/select), each stage one register.
// The pipe advances whenever the output register is empty or taken; when
// the receiver stalls every stage holds and s_axis_tready stays low while
// the output beat waits.
// Reset clears all valid bits; no results are pending after reset.
`default_nettype none
`include "float_to_int_saturating_truncate_defines.svh"
module float_to_int_saturating_truncate (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // float_bits
  input  wire logic [2:0]  s_axis_tuser,   // source_single, dest_size[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata    // int_value
);
  logic          adv;
  logic          v1_q, v2_q, v3_q;
  f2i_pkg::unp_t u_d, u1_q;
  logic [63:0]   mag_d, mag_q, res_d, res_q;
  f2i_pkg::cls_e cls2_q;
  logic          neg2_q;
  f2i_pkg::size_e size2_q;

  assign adv = !v3_q || m_axis_tready;
  assign s_axis_tready = adv;

  f2i_unpack u_unpack (
    .bits_i  (s_axis_tdata),
    .single_i(s_axis_tuser[0]),
    .size_i  (s_axis_tuser[2:1]),
    .unp_o   (u_d)
  );

  f2i_shift u_shift (
    .unp_i(u1_q),
    .mag_o(mag_d)
  );

  always_comb begin
    case (cls2_q)
      f2i_pkg::CLS_SAT: res_d = f2i_pkg::sat_val(size2_q, neg2_q);
      f2i_pkg::CLS_NUM: res_d = neg2_q ? (64'd0 - mag_q) : mag_q;
      default:          res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      u1_q    <= u_d;
      mag_q   <= mag_d;
      cls2_q  <= u1_q.cls;
      neg2_q  <= u1_q.neg;
      size2_q <= u1_q.size;
      res_q   <= res_d;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = res_q;

  `F2I_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `F2I_ASSERT(a_ready, s_axis_tready == (!v3_q || m_axis_tready))
  `F2I_ASSERT_NEXT(a_flow, adv && v2_q, v3_q)
endmodule
`default_nettype wire
